// ===== rtl/core/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int RX_BUF_BYTES_DEF = 64;
  // Bytes of the receive buffer taken by start, length, two CRC and end bytes.
  localparam int FRAME_OVERHEAD   = 5;

  localparam int LEN_W = 8;
  localparam int OUT_W = 6;

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [7:0]  END_BYTE   = 8'hDD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Depth of the frame descriptor queue; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_END
  } crcfr_phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD
  } crcfr_bstate_t;

  // Payload buffer write from the front end.
  typedef struct packed {
    logic             wr_en;
    logic [LEN_W-1:0] wr_addr;
    logic [7:0]       wr_data;
  } crcfr_wr_t;

  // Verified frame descriptor: push side and head side.
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] length;
  } crcfr_desc_t;

  // Conditions that hold the front end.
  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_busy;
  } crcfr_hold_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front
// Frame parser: hunts for the start byte, checks length, runs the CRC,
// writes payload bytes to the buffer and queues verified frames.
// ----------------------------------------------------------------------------
module crcfr_front
  import crcfr_pkg::*;
#(
  parameter int RECEIVE_BUFFER_BYTES = RX_BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  crcfr_hold_t hold,
  output crcfr_wr_t   wr,
  output crcfr_desc_t push
);

  localparam int MAX_PAYLOAD = RECEIVE_BUFFER_BYTES - FRAME_OVERHEAD;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  crcfr_phase_t     phase, phase_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] bytes_taken, bytes_taken_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      received_crc, received_crc_next;
  logic [LEN_W-1:0] taken_inc;
  logic             accept;

  assign taken_inc = bytes_taken + LEN_W'(1);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      bytes_taken  <= '0;
      running_crc  <= CRC_INIT;
      received_crc <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_taken  <= bytes_taken_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_taken_next  = bytes_taken;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    wr                = '{wr_en: 1'b0, wr_addr: bytes_taken, wr_data: rx_byte};
    push              = '{valid: 1'b0, length: frame_length};

    // Hold data bytes while the buffer is still being drained, and the end
    // byte while there is no room to queue a descriptor.
    case (phase)
      PH_DATA: in_stall = !hold.q_empty || hold.back_busy;
      PH_END:  in_stall = hold.q_full;
      default: in_stall = 1'b0;
    endcase

    if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == START_BYTE) begin
            running_crc_next = CRC_INIT;
            bytes_taken_next = '0;
            phase_next       = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte > MAX_LEN) begin
            phase_next = PH_HUNT;
          end else begin
            frame_length_next = rx_byte;
            bytes_taken_next  = '0;
            phase_next        = (rx_byte == 8'd0) ? PH_CRC_HI : PH_DATA;
          end
        end
        PH_DATA: begin
          wr.wr_en         = 1'b1;
          running_crc_next = crc16_update(running_crc, rx_byte);
          bytes_taken_next = taken_inc;
          if (taken_inc >= frame_length) begin
            phase_next = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          received_crc_next = {rx_byte, 8'h00};
          phase_next        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc_next = {received_crc[15:8], rx_byte};
          phase_next        = PH_END;
        end
        PH_END: begin
          push.valid = (rx_byte == END_BYTE) && (received_crc == running_crc);
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/crcfr_queue.sv =====
// ----------------------------------------------------------------------------
// crcfr_queue
// Short FIFO of verified frame descriptors between front and back end.
// ----------------------------------------------------------------------------
module crcfr_queue
  import crcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  crcfr_desc_t push,
  input  logic        pop,
  output crcfr_desc_t head,
  output logic        full
);

  logic [LEN_W-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);
  assign head    = '{valid: (count != '0), length: entries[rd_ptr]};

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("descriptor pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("descriptor popped from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == '0) && !do_push |=> (count == '0))
    else $error("queue count moved without a push");
`endif

endmodule

// ===== rtl/core/crcfr_back.sv =====
// ----------------------------------------------------------------------------
// crcfr_back
// Payload buffer and emitter: replays a verified frame from the buffer
// one byte at a time into the output register.
// ----------------------------------------------------------------------------
module crcfr_back
  import crcfr_pkg::*;
#(
  parameter int RECEIVE_BUFFER_BYTES = RX_BUF_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  crcfr_wr_t         wr,
  input  crcfr_desc_t       head,
  output logic              pop,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        payload_byte,
  output logic [OUT_W-1:0]  payload_index,
  output logic [OUT_W-1:0]  payload_length,
  output logic              empty_frame,
  output logic              last
);

  localparam int MAX_PAYLOAD = RECEIVE_BUFFER_BYTES - FRAME_OVERHEAD;
  localparam int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       store [MAX_PAYLOAD];
  logic [7:0]       rd_data;
  logic             rd_en;

  crcfr_bstate_t    state, state_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] idx_inc;
  logic             out_free;
  logic             load_byte;
  logic             load_empty;
  logic             is_last;

  assign idx_inc  = idx + LEN_W'(1);
  assign is_last  = (idx_inc == len);
  assign out_free = !out_valid || !out_stall;
  assign busy     = (state != B_IDLE);

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      store[wr.wr_addr[AW-1:0]] <= wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      len   <= len_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    len_next   = len;
    pop        = 1'b0;
    rd_en      = 1'b0;
    load_byte  = 1'b0;
    load_empty = 1'b0;
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          if (head.length == '0) begin
            if (out_free) begin
              pop        = 1'b1;
              load_empty = 1'b1;
            end
          end else begin
            pop        = 1'b1;
            len_next   = head.length;
            idx_next   = '0;
            state_next = B_READ;
          end
        end
      end
      B_READ: begin
        rd_en      = 1'b1;
        state_next = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          load_byte = 1'b1;
          idx_next  = idx_inc;
          state_next = is_last ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      payload_byte   <= rd_data;
      payload_index  <= idx[OUT_W-1:0];
      payload_length <= len[OUT_W-1:0];
      empty_frame    <= 1'b0;
      last           <= is_last;
    end else if (load_empty) begin
      payload_byte   <= '0;
      payload_index  <= '0;
      payload_length <= '0;
      empty_frame    <= 1'b1;
      last           <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_read_before_load: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOAD) |-> ($past(state) == B_READ || $past(state) == B_LOAD))
    else $error("byte loaded without a buffer read");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> (idx < len))
    else $error("replay index ran past the frame length");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> last)
    else $error("empty frame result without last mark");
`endif

endmodule

// ===== rtl/core/crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Framed serial receiver with CRC-16 Modbus check and payload replay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request on rx_byte (in_valid /
//   in_stall). Frames are 0xAA, length, payload, CRC high, CRC low, 0xDD.
//   Output channel: one request per payload byte of a verified frame with
//   index, length and a last mark; a zero-length frame gives a single
//   request flagged empty_frame (out_valid / out_stall).
//   The front end takes one byte per cycle unless it holds in_stall, and updates the CRC in that cycle.
//   Frames with a bad CRC, bad end byte or oversized length are dropped.
//   The first result passes the descriptor queue, the registered buffer read
//   and the output register load after the end byte is taken; an empty frame
//   goes from the queue straight to the output register. Each further byte
//   takes another buffer read followed by an output register load. Payload
//   bytes of the next frame are held (in_stall) until the previous frame has
//   drained; header, CRC and stray bytes keep flowing. Up to two verified
//   frames can wait in the descriptor queue.
//   Reset: rst (synchronous) returns to hunting, empties the queue and clears
//   out_valid. Buffer contents are not cleared.
//   Receiver stall: out_stall holds the output register; replay pauses and,
//   once the queue fills, the end byte of a later frame is held too.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
  import crcfr_pkg::*;
#(
  parameter int RECEIVE_BUFFER_BYTES = RX_BUF_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       payload_byte,
  output logic [OUT_W-1:0] payload_index,
  output logic [OUT_W-1:0] payload_length,
  output logic             empty_frame,
  output logic             last
);

  crcfr_wr_t   wr;
  crcfr_desc_t push;
  crcfr_desc_t head;
  crcfr_hold_t hold;
  logic        pop;
  logic        q_full;
  logic        back_busy;

  // Front end holds data bytes while the buffer is in use downstream.
  assign hold = '{q_full: q_full, q_empty: !head.valid, back_busy: back_busy};

  crcfr_front #(
    .RECEIVE_BUFFER_BYTES(RECEIVE_BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .hold     (hold),
    .wr       (wr),
    .push     (push)
  );

  crcfr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  crcfr_back #(
    .RECEIVE_BUFFER_BYTES(RECEIVE_BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .head           (head),
    .pop            (pop),
    .busy           (back_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .payload_length (payload_length),
    .empty_frame    (empty_frame),
    .last           (last)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    wr.wr_en |-> (!back_busy && !head.valid))
    else $error("buffer written while a frame is still being replayed");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("verified frame pushed with no queue room");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !back_busy)
    else $error("descriptor taken while replay is busy");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Byte-stream test of the CRC-16 framed receiver. Frames are built here with
// a correct or a corrupted CRC or end byte, mixed with oversize lengths and
// line noise. A payload tracker follows every accepted byte to predict the
// replayed payload, and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
  import crcfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD    = RX_BUF_BYTES_DEF - FRAME_OVERHEAD;
  // Longest legal quiet stretch is the forced receiver hold plus one frame drain;
  // allow several times that.
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 50;

  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_BAD_END
  } frame_fault_t;

  // Follows the receiver byte by byte and queues the payload it should replay.
  class payload_checker;
    typedef struct packed {
      logic [7:0]       data;
      logic [OUT_W-1:0] index;
      logic [OUT_W-1:0] length;
      logic             empty;
      logic             last;
    } payload_rec_t;

    crcfr_phase_t rx_phase;
    int unsigned  frame_size;
    int unsigned  bytes_taken;
    logic [15:0]  running_crc;
    logic [15:0]  received_crc;
    logic [7:0]   frame_bytes [RX_BUF_BYTES_DEF];
    payload_rec_t pending [$];
    int           errors;

    function new();
      rx_phase     = PH_HUNT;
      frame_size   = 0;
      bytes_taken  = 0;
      running_crc  = CRC_INIT;
      received_crc = '0;
      errors       = 0;
    endfunction

    // Bit-serial form of the reflected CRC-16 update, LSB first.
    static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ b[k];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void take_rx_byte(input logic [7:0] b);
      payload_rec_t rec;
      case (rx_phase)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            running_crc = CRC_INIT;
            bytes_taken = 0;
            rx_phase    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b > MAX_PAYLOAD) begin
            rx_phase = PH_HUNT;
          end else begin
            frame_size  = b;
            bytes_taken = 0;
            rx_phase    = (b == 0) ? PH_CRC_HI : PH_DATA;
          end
        end
        PH_DATA: begin
          frame_bytes[bytes_taken] = b;
          running_crc = crc_step(running_crc, b);
          bytes_taken++;
          if (bytes_taken >= frame_size) begin
            rx_phase = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          received_crc = {b, 8'h00};
          rx_phase     = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc[7:0] = b;
          rx_phase          = PH_END;
        end
        PH_END: begin
          if (b == END_BYTE && received_crc == running_crc) begin
            if (frame_size == 0) begin
              rec = '{8'h00, '0, '0, 1'b1, 1'b1};
              pending.push_back(rec);
            end else begin
              for (int i = 0; i < frame_size; i++) begin
                rec.data   = frame_bytes[i];
                rec.index  = OUT_W'(i);
                rec.length = OUT_W'(frame_size);
                rec.empty  = 1'b0;
                rec.last   = (i + 1 == frame_size);
                pending.push_back(rec);
              end
            end
          end
          rx_phase = PH_HUNT;
        end
        default: rx_phase = PH_HUNT;
      endcase
    endfunction

    function void check_payload(input payload_rec_t got);
      payload_rec_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected payload result, actual byte %h index %0d length %0d",
                 $time, got.data, got.index, got.length);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        $display("%0t: payload mismatch, expected byte %h idx %0d len %0d empty %b last %b",
                 $time, want.data, want.index, want.length, want.empty, want.last);
        $display("%0t:                     actual byte %h idx %0d len %0d empty %b last %b",
                 $time, got.data, got.index, got.length, got.empty, got.last);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       payload_byte;
  logic [OUT_W-1:0] payload_index;
  logic [OUT_W-1:0] payload_length;
  logic             empty_frame;
  logic             last;

  payload_checker tracker = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_items      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  bit hold_armed    = 1'b0;
  bit hold_used     = 1'b0;

  crc16_frame_receiver u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .payload_length (payload_length),
    .empty_frame    (empty_frame),
    .last           (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: check every accepted result, then pick next cycle's stall.
  // A long hold, once armed, is counted down here while the sender keeps going.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_payload({payload_byte, payload_index, payload_length, empty_frame, last});
    end
    if (hold_armed && !hold_used) begin
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one byte, idling first at random; hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_rx_byte(b);
  endtask

  // Build and send a whole frame; corrupt the CRC or the end byte on request.
  task automatic send_frame(input logic [7:0] body [$], input frame_fault_t fault);
    logic [15:0] crc;
    logic [7:0]  tail;
    // Flush any half-open frame left by noise so this one starts from hunting.
    while (tracker.rx_phase != PH_HUNT) begin
      send_byte(8'h00);
    end
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = payload_checker::crc_step(crc, body[i]);
    end
    if (fault == FRAME_BAD_CRC) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    tail = END_BYTE;
    if (fault == FRAME_BAD_END) begin
      tail = 8'($urandom_range(254));
      if (tail == END_BYTE) begin
        tail = 8'hFF;
      end
    end
    send_byte(START_BYTE);
    send_byte(8'(body.size()));
    foreach (body[i]) begin
      send_byte(body[i]);
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte(tail);
    rx_items += body.size() + 5;
  endtask

  // Start byte and a length past the buffer, then a little line noise.
  task automatic send_oversize(input logic [7:0] len);
    while (tracker.rx_phase != PH_HUNT) begin
      send_byte(8'h00);
    end
    send_byte(START_BYTE);
    send_byte(len);
    rx_items += 2;
    repeat ($urandom_range(3)) begin
      send_byte(8'($urandom_range(255)));
      rx_items++;
    end
  endtask

  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(19);
    if (r == 0) begin
      return START_BYTE;
    end else if (r == 1) begin
      return END_BYTE;
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed frames with random content; some broken frames and noise.
  task automatic run_random(input int upto);
    logic [7:0] body [$];
    int         pick;
    int         len;
    while (rx_items < upto) begin
      pick = $urandom_range(99);
      if (pick >= 93) begin
        send_oversize(8'($urandom_range(255, MAX_PAYLOAD + 1)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAYLOAD, 48) : $urandom_range(8);
        body.delete();
        repeat (len) body.push_back(pick_payload_byte());
        if (pick < 76) begin
          send_frame(body, FRAME_GOOD);
        end else if (pick < 86) begin
          send_frame(body, FRAME_BAD_CRC);
        end else begin
          send_frame(body, FRAME_BAD_END);
        end
      end
    end
  endtask

  initial begin
    logic [7:0] body [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes, empty frame, byte extremes, start and end bytes
    // inside a payload, bad CRC, bad end byte, oversize lengths.
    send_byte(8'h00);
    send_byte(8'h55);
    body = {};
    send_frame(body, FRAME_GOOD);
    body = {8'hFF};
    send_frame(body, FRAME_GOOD);
    body = {8'h00, START_BYTE, END_BYTE};
    send_frame(body, FRAME_GOOD);
    body = {8'h5A};
    send_frame(body, FRAME_BAD_CRC);
    body = {};
    send_frame(body, FRAME_BAD_END);
    send_oversize(8'(MAX_PAYLOAD + 1));
    send_oversize(8'hFF);

    // Random, phase one: sender idles lightly, receiver stalls often.
    send_idle_pct = 18;
    recv_idle_pct = 53;
    body.delete();
    repeat (MAX_PAYLOAD) body.push_back(8'($urandom_range(255)));
    send_frame(body, FRAME_GOOD);
    run_random(150);

    // Phase two: the other way round.
    send_idle_pct = 53;
    recv_idle_pct = 18;
    run_random(260);

    // Phase three: full rate both ways, opened by a long receiver hold so the
    // descriptor queue fills and the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    run_random(360);

    // Drain: stop offering, wait for every predicted result, then linger.
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_front.sv
rtl/core/crcfr_queue.sv
rtl/core/crcfr_back.sv
rtl/core/crc16_frame_receiver.sv
test/testbench.sv
